// ===== rtl/lcdn_pkg.sv =====
// shared types and constants for the 4-bit character lcd controller
// no dependencies; used by lcdn_cfg, lcdn_core and char_lcd_nibble_interface
package lcdn_pkg;

    localparam int DEF_TICK_COUNT_BITS = 16;
    localparam int CFG_INDEX_BITS      = 3;
    localparam int CFG_DATA_BITS       = 16;

    localparam logic [15:0] TICKS_PER_MS = 16'd1000;

    localparam logic [15:0] RST_ENABLE_HIGH     = 16'd10;
    localparam logic [15:0] RST_ENABLE_LOW      = 16'd100;
    localparam logic [15:0] RST_LONG_COMMAND    = 16'(2 * TICKS_PER_MS);
    localparam logic [15:0] RST_POWER_ON        = 16'(40 * TICKS_PER_MS);
    localparam logic [15:0] RST_INIT_FIRST_GAP  = 16'(5 * TICKS_PER_MS);
    localparam logic [15:0] RST_INIT_SECOND_GAP = 16'd150;

    localparam logic [3:0] NIB_INIT_THREE   = 4'h3;
    localparam logic [3:0] NIB_INIT_TWO     = 4'h2;
    localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0E;
    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] CMD_HOME         = 8'h02;
    localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] DDRAM_ROW_FIRST  = 8'h80;
    localparam logic [7:0] DDRAM_ROW_SECOND = 8'hC0;
    localparam logic [7:0] LOW_NIBBLE_MASK  = 8'h0F;

    localparam logic [1:0] ROW_FIRST  = 2'd1;
    localparam logic [1:0] ROW_SECOND = 2'd2;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_COMMAND    = 3'd1,
        OP_CHAR       = 3'd2,
        OP_INIT       = 3'd3,
        OP_SET_CURSOR = 3'd4,
        OP_CLEAR      = 3'd5,
        OP_HOME       = 3'd6,
        OP_IGNORE     = 3'd7
    } t_opcode;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ENABLE_HIGH     = 3'd0,
        CFG_ENABLE_LOW      = 3'd1,
        CFG_LONG_COMMAND    = 3'd2,
        CFG_POWER_ON        = 3'd3,
        CFG_INIT_FIRST_GAP  = 3'd4,
        CFG_INIT_SECOND_GAP = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [15:0] enable_high_ticks;
        logic [15:0] enable_low_ticks;
        logic [15:0] long_command_ticks;
        logic [15:0] power_on_ticks;
        logic [15:0] init_first_gap_ticks;
        logic [15:0] init_second_gap_ticks;
    } t_cfg;

    typedef struct packed {
        logic       reg_select;
        logic       enable_pin;
        logic [3:0] bus_nibble;
        logic       busy_res;
        logic       accepted;
    } t_result;

endpackage

// ===== rtl/char_lcd_nibble_interface.sv =====
// top level of the 4-bit character lcd controller: config port, sequencer, output buffer
// depends on lcdn_pkg, lcdn_cfg and lcdn_core
// the result word of an accepted item is registered into the output buffer
// throughput: one word per cycle when not stalled; state updates in the accepting cycle
// a two-entry output buffer keeps input flowing while one result waits
// reset (synchronous, active low) puts the sequencer idle and loads the default timings
module char_lcd_nibble_interface #(
    parameter int TICK_COUNT_BITS = lcdn_pkg::DEF_TICK_COUNT_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [2:0]                          i_opcode,
    input  logic [7:0]                          i_byte_value,
    input  logic [1:0]                          i_row,
    input  logic [7:0]                          i_column,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_reg_select,
    output logic                                o_read_write,
    output logic                                o_enable_pin,
    output logic [3:0]                          o_bus_nibble,
    output logic                                o_busy_res,
    output logic                                o_accepted,
    input  logic                                i_cfg_we,
    input  logic [lcdn_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [lcdn_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import lcdn_pkg::*;

    t_cfg    w_cfg;
    t_result w_result;
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    w_in_accept;
    logic    w_take;

    lcdn_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    lcdn_core #(
        .TICK_COUNT_BITS (TICK_COUNT_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_in_accept),
        .i_opcode     (i_opcode),
        .i_byte_value (i_byte_value),
        .i_row        (i_row),
        .i_column     (i_column),
        .i_cfg        (w_cfg),
        .o_result     (w_result)
    );

    assign w_in_accept = i_in_valid & ~r_skid_valid;
    assign w_take      = r_out_valid & ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_in_accept;
            end
        end else if (w_in_accept) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_in_accept) begin
                r_out <= w_result;
            end
        end else if (w_in_accept) begin
            if (r_out_valid) begin
                r_skid <= w_result;
            end else begin
                r_out <= w_result;
            end
        end
    end

    assign o_in_stall   = r_skid_valid;
    assign o_out_valid  = r_out_valid;
    assign o_reg_select = r_out.reg_select;
    assign o_read_write = 1'b0;
    assign o_enable_pin = r_out.enable_pin;
    assign o_bus_nibble = r_out.bus_nibble;
    assign o_busy_res   = r_out.busy_res;
    assign o_accepted   = r_out.accepted;

    // the second buffer entry only fills behind a waiting word
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word without output word");

    // a taken request always starts a sequence
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.accepted) |-> r_out.busy_res)
        else $error("accepted request left the sequencer idle");

    // the enable strobe is never left high once the sequencer is idle
    a_idle_enable_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.busy_res) |-> !r_out.enable_pin)
        else $error("enable high while idle");

    // a full buffer drains before new input is taken
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_out_stall) |=> r_skid_valid)
        else $error("skid word lost while output stalled");

endmodule

// ===== rtl/lcdn_cfg.sv =====
// timing configuration registers of the lcd controller
// depends on lcdn_pkg
module lcdn_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_we,
    input  logic [lcdn_pkg::CFG_INDEX_BITS-1:0] i_index,
    input  logic [lcdn_pkg::CFG_DATA_BITS-1:0]  i_data,
    output lcdn_pkg::t_cfg                      o_cfg
);
    import lcdn_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable_high_ticks     <= RST_ENABLE_HIGH;
            r_cfg.enable_low_ticks      <= RST_ENABLE_LOW;
            r_cfg.long_command_ticks    <= RST_LONG_COMMAND;
            r_cfg.power_on_ticks        <= RST_POWER_ON;
            r_cfg.init_first_gap_ticks  <= RST_INIT_FIRST_GAP;
            r_cfg.init_second_gap_ticks <= RST_INIT_SECOND_GAP;
        end else if (i_we) begin
            case (t_cfg_index'(i_index))
                CFG_ENABLE_HIGH:     r_cfg.enable_high_ticks     <= i_data;
                CFG_ENABLE_LOW:      r_cfg.enable_low_ticks      <= i_data;
                CFG_LONG_COMMAND:    r_cfg.long_command_ticks    <= i_data;
                CFG_POWER_ON:        r_cfg.power_on_ticks        <= i_data;
                CFG_INIT_FIRST_GAP:  r_cfg.init_first_gap_ticks  <= i_data;
                CFG_INIT_SECOND_GAP: r_cfg.init_second_gap_ticks <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/lcdn_core.sv =====
// sequencer of the lcd controller: phase, wait counter, held byte and pin state
// depends on lcdn_pkg; timing comes from lcdn_cfg
module lcdn_core #(
    parameter int TICK_COUNT_BITS = lcdn_pkg::DEF_TICK_COUNT_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [2:0]          i_opcode,
    input  logic [7:0]          i_byte_value,
    input  logic [1:0]          i_row,
    input  logic [7:0]          i_column,
    input  lcdn_pkg::t_cfg      i_cfg,
    output lcdn_pkg::t_result   o_result
);
    import lcdn_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_POWER = 3'd1,
        PH_EHIGH = 3'd2,
        PH_ELOW  = 3'd3,
        PH_GAP   = 3'd4,
        PH_LONG  = 3'd5
    } t_phase;

    typedef logic [TICK_COUNT_BITS-1:0] t_ticks;

    typedef struct packed {
        t_phase     phase;
        t_ticks     wait_count;
        logic [7:0] held_byte;
        logic       held_select;
        logic       low_half_next;
        logic [3:0] init_step;
        logic       long_wait_pending;
        logic [3:0] pin_nibble;
        logic       pin_enable;
    } t_state;

    localparam logic [31:0] TickMax = 32'((64'd1 << TICK_COUNT_BITS) - 64'd1);

    // init sequence steps
    localparam logic [3:0] STEP_NONE     = 4'd0;
    localparam logic [3:0] STEP_POWER    = 4'd1;
    localparam logic [3:0] STEP_NIB_A    = 4'd2;
    localparam logic [3:0] STEP_NIB_B    = 4'd3;
    localparam logic [3:0] STEP_NIB_C    = 4'd4;
    localparam logic [3:0] STEP_NIB_TWO  = 4'd5;
    localparam logic [3:0] STEP_FUNC_SET = 4'd6;
    localparam logic [3:0] STEP_DISP_ON  = 4'd7;
    localparam logic [3:0] STEP_CLEAR    = 4'd8;
    localparam logic [3:0] STEP_ENTRY    = 4'd9;

    // longest run of zero-length waits that can finish within one word
    localparam int SettleSteps = 4;

    t_state     r_state;
    t_state     n_state;
    t_opcode    w_opcode;
    logic [7:0] w_cursor;
    logic       w_acc;
    logic       w_run;

    function automatic t_ticks f_sat(logic [15:0] v, logic at_least_one);
        logic [31:0] w;
        w = 32'(v);
        if (w > TickMax) w = TickMax;
        if (at_least_one && w == 32'd0) w = 32'd1;
        return t_ticks'(w);
    endfunction

    function automatic t_state f_start_nibble(t_state s, logic [3:0] v, t_cfg c);
        s.pin_nibble = v;
        s.pin_enable = 1'b1;
        s.phase      = PH_EHIGH;
        s.wait_count = f_sat(c.enable_high_ticks, 1'b1);
        return s;
    endfunction

    function automatic t_state f_start_byte(t_state s, logic [7:0] b, logic sel,
                                            logic longw, t_cfg c);
        s.held_byte         = b;
        s.held_select       = sel;
        s.low_half_next     = 1'b1;
        s.long_wait_pending = longw;
        return f_start_nibble(s, b[7:4], c);
    endfunction

    function automatic t_state f_start_action(t_state s, logic [3:0] k, t_cfg c);
        s.init_step   = k;
        s.held_select = 1'b0;
        case (k)
            STEP_POWER: begin
                s.phase      = PH_POWER;
                s.wait_count = f_sat(c.power_on_ticks, 1'b0);
            end
            STEP_NIB_A, STEP_NIB_B, STEP_NIB_C: s = f_start_nibble(s, NIB_INIT_THREE, c);
            STEP_NIB_TWO:  s = f_start_nibble(s, NIB_INIT_TWO, c);
            STEP_FUNC_SET: s = f_start_byte(s, CMD_FUNCTION_SET, 1'b0, 1'b0, c);
            STEP_DISP_ON:  s = f_start_byte(s, CMD_DISPLAY_ON, 1'b0, 1'b0, c);
            STEP_CLEAR:    s = f_start_byte(s, CMD_CLEAR, 1'b0, 1'b1, c);
            STEP_ENTRY:    s = f_start_byte(s, CMD_ENTRY_MODE, 1'b0, 1'b0, c);
            default: begin
                s.init_step  = STEP_NONE;
                s.phase      = PH_IDLE;
                s.wait_count = '0;
            end
        endcase
        return s;
    endfunction

    function automatic t_state f_next_action(t_state s, t_cfg c);
        if (s.init_step == STEP_NONE || s.init_step >= STEP_ENTRY) begin
            s.init_step  = STEP_NONE;
            s.phase      = PH_IDLE;
            s.wait_count = '0;
        end else begin
            s = f_start_action(s, s.init_step + 4'd1, c);
        end
        return s;
    endfunction

    function automatic t_state f_unit_done(t_state s, t_cfg c);
        if (s.init_step == STEP_NIB_A) begin
            s.phase      = PH_GAP;
            s.wait_count = f_sat(c.init_first_gap_ticks, 1'b0);
        end else if (s.init_step == STEP_NIB_B) begin
            s.phase      = PH_GAP;
            s.wait_count = f_sat(c.init_second_gap_ticks, 1'b0);
        end else begin
            s = f_next_action(s, c);
        end
        return s;
    endfunction

    // one expired phase moves on
    function automatic t_state f_settle_step(t_state s, t_cfg c);
        case (s.phase)
            PH_POWER: s = f_start_action(s, STEP_NIB_A, c);
            PH_EHIGH: begin
                s.pin_enable = 1'b0;
                s.phase      = PH_ELOW;
                s.wait_count = f_sat(c.enable_low_ticks, 1'b1);
            end
            PH_ELOW: begin
                if (s.low_half_next) begin
                    s.low_half_next = 1'b0;
                    s = f_start_nibble(s, 4'(s.held_byte & LOW_NIBBLE_MASK), c);
                end else if (s.long_wait_pending) begin
                    s.long_wait_pending = 1'b0;
                    s.phase             = PH_LONG;
                    s.wait_count        = f_sat(c.long_command_ticks, 1'b0);
                end else begin
                    s = f_unit_done(s, c);
                end
            end
            default: s = f_next_action(s, c);
        endcase
        return s;
    endfunction

    assign w_opcode = t_opcode'(i_opcode);
    assign w_cursor = i_column - 8'd1;

    always_comb begin
        n_state = r_state;
        w_acc   = 1'b0;
        w_run   = 1'b0;
        if (i_step) begin
            if (w_opcode == OP_TICK) begin
                w_run = 1'b1;
                if (r_state.phase != PH_IDLE && r_state.wait_count != '0) begin
                    n_state.wait_count = r_state.wait_count - t_ticks'(1);
                end
            end else if (r_state.phase == PH_IDLE && w_opcode != OP_IGNORE) begin
                w_acc = 1'b1;
                w_run = 1'b1;
                case (w_opcode)
                    OP_COMMAND: n_state = f_start_byte(n_state, i_byte_value, 1'b0, 1'b0, i_cfg);
                    OP_CHAR:    n_state = f_start_byte(n_state, i_byte_value, 1'b1, 1'b0, i_cfg);
                    OP_INIT: begin
                        n_state.held_select       = 1'b0;
                        n_state.pin_enable        = 1'b0;
                        n_state.pin_nibble        = '0;
                        n_state.low_half_next     = 1'b0;
                        n_state.long_wait_pending = 1'b0;
                        n_state = f_start_action(n_state, STEP_POWER, i_cfg);
                    end
                    OP_SET_CURSOR: begin
                        if (i_row == ROW_FIRST) begin
                            n_state = f_start_byte(n_state, w_cursor | DDRAM_ROW_FIRST,
                                                   1'b0, 1'b0, i_cfg);
                        end else if (i_row == ROW_SECOND) begin
                            n_state = f_start_byte(n_state, w_cursor | DDRAM_ROW_SECOND,
                                                   1'b0, 1'b0, i_cfg);
                        end else begin
                            w_acc = 1'b0;
                        end
                    end
                    OP_CLEAR: n_state = f_start_byte(n_state, CMD_CLEAR, 1'b0, 1'b1, i_cfg);
                    default:  n_state = f_start_byte(n_state, CMD_HOME, 1'b0, 1'b1, i_cfg);
                endcase
            end
        end
        // zero-length waits complete within the same word
        for (int g = 0; g < SettleSteps; g++) begin
            if (w_run && n_state.phase != PH_IDLE && n_state.wait_count == '0) begin
                n_state = f_settle_step(n_state, i_cfg);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

    assign o_result.reg_select = n_state.held_select;
    assign o_result.enable_pin = n_state.pin_enable;
    assign o_result.bus_nibble = n_state.pin_nibble;
    assign o_result.busy_res   = (n_state.phase != PH_IDLE);
    assign o_result.accepted   = w_acc;

endmodule
